// ----- rtl/infix_to_postfix_converter_unit_assert.svh -----
// Assertion macros for the infix-to-postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ITP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Character codes
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Precedence levels
    localparam logic [2:0] PREC_POW   = 3'd5;
    localparam logic [2:0] PREC_MUL   = 3'd4;
    localparam logic [2:0] PREC_ADD   = 3'd3;
    localparam logic [2:0] PREC_OTHER = 3'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_EV,
        ST_PUSH,
        ST_POST,
        ST_DONE
    } t_state;

    // What the pop loop is doing
    typedef enum logic [1:0] {
        MODE_CLOSE,
        MODE_OP,
        MODE_FLUSH
    } t_mode;

    function automatic logic [2:0] prec_of(input logic [7:0] c);
        logic [2:0] p;
        p = PREC_OTHER;
        if (c == CH_POW) begin
            p = PREC_POW;
        end else if (c == CH_MUL || c == CH_DIV) begin
            p = PREC_MUL;
        end else if (c == CH_ADD || c == CH_SUB) begin
            p = PREC_ADD;
        end
        return p;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_POW) || (c == CH_MUL) || (c == CH_DIV) ||
               (c == CH_ADD) || (c == CH_SUB);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itp_ram.sv -----
`default_nettype none

// Simple dual-port RAM, registered read
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/infix_to_postfix_converter_unit.sv -----
`default_nettype none

// Infix-to-postfix converter, one character per input transaction; one input at a time.
// A plain character or '(' takes just the accept, post and done steps; its result is sent
// out on leaving done. Each stack entry read adds a RAM read step and a compare step on the
// shared precedence unit, an operator push a push step, a pop loop that ends on an empty
// stack a read step; the end flag flush reads every entry. Output stalls add their length.
// Reset (sync, active low) empties the stack and clears the error latch.
module infix_to_postfix_converter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_end_of_expr,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_out_char,
    output logic            o_last_of_run,
    output logic            o_error_flag
);

    itp_pkg::t_state r_state, n_state;
    itp_pkg::t_mode  r_mode,  n_mode;

    logic [itp_pkg::CNT_W-1:0] r_count, n_count;
    logic [itp_pkg::CNT_W-1:0] r_paren, n_paren;
    logic                      r_err,   n_err;
    logic [7:0]                r_char,  n_char;
    logic [2:0]                r_prec,  n_prec;
    logic                      r_last,  n_last;
    logic [7:0]                r_hold,  n_hold;
    logic                      r_hold_v, n_hold_v;
    logic                      r_ov,    n_ov;
    logic [7:0]                r_oc,    n_oc;
    logic                      r_ol,    n_ol;
    logic                      r_oe,    n_oe;

    logic                       in_acc;
    logic                       can_move;
    logic                       full;
    logic                       empty;
    logic [itp_pkg::CNT_W-1:0]  cnt_dec;
    logic [7:0]                 top;
    logic                       top_open;
    logic                       top_ge;
    logic                       emit_go;
    logic                       mem_we;
    logic [7:0]                 mem_wdata;
    logic                       mem_re;
    logic                       over_depth;
    logic                       done_leave;

    assign o_in_stall = (r_state != itp_pkg::ST_IDLE);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign can_move = !r_ov || !i_out_stall;
    assign full     = (r_count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign empty    = (r_count == '0);
    assign cnt_dec  = r_count - itp_pkg::CNT_W'(1);
    assign top_open = (top == itp_pkg::CH_OPEN);
    // shared compare: stacked operator binds at least as tight
    assign top_ge   = (itp_pkg::prec_of(top) >= r_prec);

    // Operator stack storage
    itp_ram #(
        .WIDTH(8),
        .DEPTH(itp_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_count[itp_pkg::ADDR_W-1:0]),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(cnt_dec[itp_pkg::ADDR_W-1:0]),
        .o_rdata(top)
    );

    // Pop with emit may go once the held result can leave
    always_comb begin
        emit_go = 1'b0;
        if (r_state == itp_pkg::ST_POP_EV) begin
            unique case (r_mode)
                itp_pkg::MODE_CLOSE: emit_go = !top_open;
                itp_pkg::MODE_OP:    emit_go = top_ge;
                itp_pkg::MODE_FLUSH: emit_go = 1'b1;
                default:             emit_go = 1'b0;
            endcase
            emit_go = emit_go && (!r_hold_v || can_move);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_char == itp_pkg::CH_CLOSE || itp_pkg::is_op(i_in_char)) begin
                        n_state = itp_pkg::ST_POP_RD;
                    end else begin
                        n_state = itp_pkg::ST_POST;
                    end
                end
            end
            itp_pkg::ST_POP_RD: begin
                if (!empty) begin
                    n_state = itp_pkg::ST_POP_EV;
                end else begin
                    unique case (r_mode)
                        itp_pkg::MODE_CLOSE: n_state = itp_pkg::ST_POST;
                        itp_pkg::MODE_OP:    n_state = itp_pkg::ST_PUSH;
                        itp_pkg::MODE_FLUSH: n_state = itp_pkg::ST_DONE;
                        default:             n_state = itp_pkg::ST_DONE;
                    endcase
                end
            end
            itp_pkg::ST_POP_EV: begin
                if (emit_go) begin
                    n_state = itp_pkg::ST_POP_RD;
                end else if (r_mode == itp_pkg::MODE_CLOSE && top_open) begin
                    n_state = itp_pkg::ST_POST;
                end else if (r_mode == itp_pkg::MODE_OP && !top_ge) begin
                    n_state = itp_pkg::ST_PUSH;
                end
            end
            itp_pkg::ST_PUSH: n_state = itp_pkg::ST_POST;
            itp_pkg::ST_POST: begin
                n_state = r_last ? itp_pkg::ST_POP_RD : itp_pkg::ST_DONE;
            end
            itp_pkg::ST_DONE: begin
                if (!r_hold_v || can_move) begin
                    n_state = itp_pkg::ST_IDLE;
                end
            end
            default: n_state = itp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_paren  = r_paren;
        n_err    = r_err;
        n_char   = r_char;
        n_prec   = r_prec;
        n_last   = r_last;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_ov     = r_ov && i_out_stall;
        n_oc     = r_oc;
        n_ol     = r_ol;
        n_oe     = r_oe;
        mem_we   = 1'b0;
        mem_wdata = r_char;
        mem_re   = 1'b0;

        unique case (r_state)
            itp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_char = i_in_char;
                    n_prec = itp_pkg::prec_of(i_in_char);
                    n_last = i_end_of_expr;
                    if (i_in_char == itp_pkg::CH_OPEN) begin
                        mem_wdata = i_in_char;
                        if (full) begin
                            n_err = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + itp_pkg::CNT_W'(1);
                            n_paren = r_paren + itp_pkg::CNT_W'(1);
                        end
                    end else if (i_in_char == itp_pkg::CH_CLOSE) begin
                        // no '(' stacked: error known before anything pops
                        n_mode = itp_pkg::MODE_CLOSE;
                        if (r_paren == '0) begin
                            n_err = 1'b1;
                        end
                    end else if (itp_pkg::is_op(i_in_char)) begin
                        n_mode = itp_pkg::MODE_OP;
                    end else begin
                        n_hold   = i_in_char;
                        n_hold_v = 1'b1;
                    end
                end
            end
            itp_pkg::ST_POP_RD: begin
                mem_re = !empty;
            end
            itp_pkg::ST_POP_EV: begin
                if (emit_go) begin
                    if (r_hold_v) begin
                        n_ov = 1'b1;
                        n_oc = r_hold;
                        n_ol = 1'b0;
                        n_oe = r_err;
                    end
                    n_hold   = top;
                    n_hold_v = 1'b1;
                    n_count  = cnt_dec;
                    if (top_open) begin
                        n_paren = r_paren - itp_pkg::CNT_W'(1);
                    end
                end else if (r_mode == itp_pkg::MODE_CLOSE && top_open) begin
                    // matching '(' is dropped
                    n_count = cnt_dec;
                    n_paren = r_paren - itp_pkg::CNT_W'(1);
                end
            end
            itp_pkg::ST_PUSH: begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + itp_pkg::CNT_W'(1);
                end
            end
            itp_pkg::ST_POST: begin
                n_mode = itp_pkg::MODE_FLUSH;
            end
            itp_pkg::ST_DONE: begin
                if (!r_hold_v || can_move) begin
                    if (r_hold_v) begin
                        n_ov     = 1'b1;
                        n_oc     = r_hold;
                        n_ol     = 1'b1;
                        n_oe     = r_err;
                        n_hold_v = 1'b0;
                    end
                    if (r_last) begin
                        n_err = 1'b0;
                    end
                end
            end
            default: begin
                n_hold_v = 1'b0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itp_pkg::ST_IDLE;
            r_mode   <= itp_pkg::MODE_FLUSH;
            r_count  <= '0;
            r_paren  <= '0;
            r_err    <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_paren  <= n_paren;
            r_err    <= n_err;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
        r_char <= n_char;
        r_prec <= n_prec;
        r_last <= n_last;
        r_hold <= n_hold;
        r_oc   <= n_oc;
        r_ol   <= n_ol;
        r_oe   <= n_oe;
    end

    assign o_out_valid   = r_ov;
    assign o_out_char    = r_oc;
    assign o_last_of_run = r_ol;
    assign o_error_flag  = r_oe;

    // Checks
    assign over_depth = (r_count > itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign done_leave = (r_state == itp_pkg::ST_DONE) && (n_state == itp_pkg::ST_IDLE);

`include "infix_to_postfix_converter_unit_assert.svh"

    `ITP_ASSERT_SAME(a_paren_le_count, 1'b1, r_paren <= r_count, "paren count above stack count")
    `ITP_ASSERT_SAME(a_count_in_range, 1'b1, !over_depth, "stack count past depth")
    `ITP_ASSERT_SAME(a_idle_no_hold, r_state == itp_pkg::ST_IDLE, !r_hold_v, "hold not empty at idle")
    `ITP_ASSERT_NEXT(a_done_last_clears_err, done_leave && r_last, !r_err, "error latch not cleared")

endmodule

`default_nettype wire
